>>> hdl/ptob_pkg.sv
// ----------------------------------------------------------------------------
// ptob_pkg
// Shared types, codes and defaults of the price-time order book.
// ----------------------------------------------------------------------------
package ptob_pkg;

  localparam int MAX_ORDERS_DEF = 256;
  localparam int MAX_LEVELS_DEF = 64;
  localparam int MAX_DEPTH_DEF  = 16;

  typedef enum logic [2:0] {
    FN_ADD       = 3'd0,
    FN_CANCEL    = 3'd1,
    FN_BEST_BID  = 3'd2,
    FN_BEST_ASK  = 3'd3,
    FN_POP_BID   = 3'd4,
    FN_POP_ASK   = 3'd5,
    FN_DEPTH_BID = 3'd6,
    FN_DEPTH_ASK = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MISS      = 3'd1,
    ST_DUP       = 3'd2,
    ST_ORD_FULL  = 3'd3,
    ST_LVL_FULL  = 3'd4
  } status_t;

  typedef struct packed {
    func_t       func;
    logic        side;
    logic [31:0] price;
    logic [31:0] order_id;
    logic [31:0] quantity;
    logic [4:0]  depth_levels;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] order_id_res;
    logic [31:0] price_res;
    logic [39:0] quantity_res;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] order_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
  } slot_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_LSCAN,
    S_LSCAN_END,
    S_SH_RD,
    S_SH_WR,
    S_ADD_NEW,
    S_UNL_RD,
    S_UNL_WR,
    S_DR_RD,
    S_DR_WR,
    S_BEST_RD,
    S_BEST_HD,
    S_BEST_SL,
    S_DEP_RD,
    S_DEP_WT,
    S_EMIT
  } state_t;

  // True when price a has priority over price b on the given side.
  function automatic logic ahead(logic sd, logic [31:0] a, logic [31:0] b);
    return sd ? (a < b) : (a > b);
  endfunction

endpackage

>>> hdl/ptob_ram.sv
// ----------------------------------------------------------------------------
// ptob_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ptob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ptob_engine.sv
// ----------------------------------------------------------------------------
// ptob_engine
// Sequencer of the order book: slot and level memories, id scan, sorted
// level insertion and removal, queries and depth reporting.
// ----------------------------------------------------------------------------
module ptob_engine #(
  parameter int MAX_ORDERS = ptob_pkg::MAX_ORDERS_DEF,
  parameter int MAX_LEVELS = ptob_pkg::MAX_LEVELS_DEF,
  parameter int MAX_DEPTH  = ptob_pkg::MAX_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ptob_pkg::req_t req,
  input  logic           req_valid,
  output logic           req_stall,
  output ptob_pkg::rsp_t res,
  output logic           res_valid,
  input  logic           res_take
);
  import ptob_pkg::*;

  localparam int SW  = $clog2(MAX_ORDERS);
  localparam int LW  = $clog2(2 * MAX_LEVELS);
  localparam int CW  = $clog2(MAX_LEVELS + 1);
  localparam int LVW = 72 + 2 * SW;
  localparam int SLW = $bits(slot_t);

  function automatic logic [LW-1:0] laddr(logic sd, logic [CW-1:0] idx);
    return sd ? (LW'(MAX_LEVELS) + LW'(idx)) : LW'(idx);
  endfunction

  state_t state, state_next;

  logic [MAX_ORDERS-1:0] vbits;
  logic [CW-1:0]  bid_cnt, ask_cnt;
  req_t           cur;
  slot_t          sd_q;
  logic [SW-1:0]  s_idx;
  logic [SW:0]    ptr;
  logic           chk_vld;
  logic [SW-1:0]  chk_addr;
  logic           found, free_found;
  logic [SW-1:0]  free_idx;
  logic           lside;
  logic [31:0]    lprice;
  logic [CW-1:0]  li, lchk, lpos, j, di, dcnt;
  logic           lchk_vld, lfound;
  logic [LVW-1:0] lw;

  logic           sd_we;
  logic [SW-1:0]  sd_waddr, sd_raddr;
  slot_t          sd_wdata, sd_rdata;
  logic           lv_we;
  logic [LW-1:0]  lv_waddr, lv_raddr;
  logic [LVW-1:0] lv_wdata, lv_rdata;
  logic           nx_we, pv_we;
  logic [SW-1:0]  nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic [SW-1:0]  pv_waddr, pv_wdata, pv_raddr, pv_rdata;

  logic [31:0]    lr_price, lw_price;
  logic [39:0]    lr_total, lw_total, tot_dec;
  logic [SW-1:0]  lr_head, lw_head, lw_tail;
  logic [CW-1:0]  cnt_l, nd;
  logic           scan_hit, lmatch, lahead, add_mode, fside;
  logic [31:0]    nd_w;
  slot_t          new_slot;

  assign lr_price = lv_rdata[LVW-1 -: 32];
  assign lr_total = lv_rdata[LVW-33 -: 40];
  assign lr_head  = lv_rdata[2*SW-1 -: SW];
  assign lw_price = lw[LVW-1 -: 32];
  assign lw_total = lw[LVW-33 -: 40];
  assign lw_head  = lw[2*SW-1 -: SW];
  assign lw_tail  = lw[SW-1:0];
  assign tot_dec  = lw_total - 40'(sd_q.quantity);

  assign cnt_l    = lside ? ask_cnt : bid_cnt;
  assign add_mode = (cur.func == FN_ADD);
  assign scan_hit = chk_vld && vbits[chk_addr] && (sd_rdata.order_id == cur.order_id);
  assign lmatch   = lchk_vld && (lr_price == lprice);
  assign lahead   = lchk_vld && add_mode && ahead(lside, lprice, lr_price);
  assign new_slot = '{order_id: cur.order_id, side: cur.side, price: cur.price,
                      quantity: cur.quantity};
  assign fside    = (req.func == FN_BEST_ASK) || (req.func == FN_POP_ASK) ||
                    (req.func == FN_DEPTH_ASK);
  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_EMIT);

  always_comb begin
    nd_w = 32'(req.depth_levels);
    if (nd_w > 32'(MAX_DEPTH)) begin
      nd_w = 32'(MAX_DEPTH);
    end
    if (nd_w > 32'(fside ? ask_cnt : bid_cnt)) begin
      nd_w = 32'(fside ? ask_cnt : bid_cnt);
    end
    nd = CW'(nd_w);
  end

  ptob_ram #(.WIDTH(SLW), .DEPTH(MAX_ORDERS)) u_slot_ram (
    .clk(clk), .we(sd_we), .waddr(sd_waddr), .wdata(sd_wdata),
    .raddr(sd_raddr), .rdata(sd_rdata)
  );

  ptob_ram #(.WIDTH(SW), .DEPTH(MAX_ORDERS)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );

  ptob_ram #(.WIDTH(SW), .DEPTH(MAX_ORDERS)) u_prev_ram (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(pv_raddr), .rdata(pv_rdata)
  );

  ptob_ram #(.WIDTH(LVW), .DEPTH(2 * MAX_LEVELS)) u_level_ram (
    .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
    .raddr(lv_raddr), .rdata(lv_rdata)
  );

  always_comb begin
    state_next = state;
    sd_we      = 1'b0;
    sd_waddr   = free_idx;
    sd_wdata   = new_slot;
    sd_raddr   = ptr[SW-1:0];
    lv_we      = 1'b0;
    lv_waddr   = '0;
    lv_wdata   = '0;
    lv_raddr   = laddr(lside, li);
    nx_we      = 1'b0;
    nx_waddr   = '0;
    nx_wdata   = '0;
    nx_raddr   = s_idx;
    pv_we      = 1'b0;
    pv_waddr   = '0;
    pv_wdata   = '0;
    pv_raddr   = s_idx;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.func)
            FN_ADD, FN_CANCEL: begin
              state_next = S_SCAN;
            end
            FN_DEPTH_BID, FN_DEPTH_ASK: begin
              state_next = (nd == '0) ? S_EMIT : S_DEP_RD;
            end
            default: begin
              state_next = ((fside ? ask_cnt : bid_cnt) == '0) ? S_EMIT : S_BEST_RD;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_hit || (chk_vld && chk_addr == SW'(MAX_ORDERS - 1))) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        if (add_mode) begin
          state_next = (found || !free_found) ? S_EMIT : S_LSCAN;
        end else begin
          state_next = found ? S_LSCAN : S_EMIT;
        end
      end
      S_LSCAN: begin
        if (lmatch || lahead || (lchk_vld && lchk == cnt_l - CW'(1)) ||
            (!lchk_vld && li >= cnt_l)) begin
          state_next = S_LSCAN_END;
        end
      end
      S_LSCAN_END: begin
        if (add_mode) begin
          if (lfound) begin
            nx_we      = 1'b1;
            nx_waddr   = lw_tail;
            nx_wdata   = free_idx;
            pv_we      = 1'b1;
            pv_waddr   = free_idx;
            pv_wdata   = lw_tail;
            lv_we      = 1'b1;
            lv_waddr   = laddr(lside, lpos);
            lv_wdata   = {lw_price, lw_total + 40'(cur.quantity), lw_head, free_idx};
            sd_we      = 1'b1;
            state_next = S_EMIT;
          end else if (cnt_l >= CW'(MAX_LEVELS)) begin
            state_next = S_EMIT;
          end else begin
            state_next = (cnt_l > lpos) ? S_SH_RD : S_ADD_NEW;
          end
        end else begin
          state_next = lfound ? S_UNL_RD : S_EMIT;
        end
      end
      S_SH_RD: begin
        lv_raddr   = laddr(lside, j - CW'(1));
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        lv_we      = 1'b1;
        lv_waddr   = laddr(lside, j);
        lv_wdata   = lv_rdata;
        state_next = (j - CW'(1) > lpos) ? S_SH_RD : S_ADD_NEW;
      end
      S_ADD_NEW: begin
        lv_we      = 1'b1;
        lv_waddr   = laddr(lside, lpos);
        lv_wdata   = {cur.price, 40'(cur.quantity), free_idx, free_idx};
        sd_we      = 1'b1;
        state_next = S_EMIT;
      end
      S_UNL_RD: begin
        state_next = S_UNL_WR;
      end
      S_UNL_WR: begin
        state_next = S_EMIT;
        lv_waddr   = laddr(lside, lpos);
        if (lw_head == s_idx && lw_tail == s_idx) begin
          if (lpos + CW'(1) < cnt_l) begin
            state_next = S_DR_RD;
          end
        end else if (lw_head == s_idx) begin
          lv_we    = 1'b1;
          lv_wdata = {lw_price, tot_dec, nx_rdata, lw_tail};
        end else if (lw_tail == s_idx) begin
          lv_we    = 1'b1;
          lv_wdata = {lw_price, tot_dec, lw_head, pv_rdata};
        end else begin
          lv_we    = 1'b1;
          lv_wdata = {lw_price, tot_dec, lw_head, lw_tail};
          nx_we    = 1'b1;
          nx_waddr = pv_rdata;
          nx_wdata = nx_rdata;
          pv_we    = 1'b1;
          pv_waddr = nx_rdata;
          pv_wdata = pv_rdata;
        end
      end
      S_DR_RD: begin
        lv_raddr   = laddr(lside, j + CW'(1));
        state_next = S_DR_WR;
      end
      S_DR_WR: begin
        lv_we      = 1'b1;
        lv_waddr   = laddr(lside, j);
        lv_wdata   = lv_rdata;
        state_next = (j + CW'(2) < cnt_l) ? S_DR_RD : S_EMIT;
      end
      S_BEST_RD: begin
        lv_raddr   = laddr(cur.func == FN_BEST_ASK || cur.func == FN_POP_ASK, '0);
        state_next = S_BEST_HD;
      end
      S_BEST_HD: begin
        sd_raddr   = lr_head;
        state_next = S_BEST_SL;
      end
      S_BEST_SL: begin
        state_next = (cur.func == FN_POP_BID || cur.func == FN_POP_ASK) ? S_LSCAN : S_EMIT;
      end
      S_DEP_RD: begin
        lv_raddr   = laddr(cur.func == FN_DEPTH_ASK, di);
        state_next = S_DEP_WT;
      end
      S_DEP_WT: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (res_take) begin
          state_next = res.last ? S_IDLE : S_DEP_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      vbits   <= '0;
      bid_cnt <= '0;
      ask_cnt <= '0;
    end else begin
      state <= state_next;
      if ((state == S_LSCAN_END && add_mode && lfound) || state == S_ADD_NEW) begin
        vbits[free_idx] <= 1'b1;
      end
      if (state == S_LSCAN_END && !add_mode) begin
        vbits[s_idx] <= 1'b0;
      end
      if (state == S_ADD_NEW) begin
        if (lside) begin
          ask_cnt <= ask_cnt + CW'(1);
        end else begin
          bid_cnt <= bid_cnt + CW'(1);
        end
      end
      if ((state == S_UNL_WR && lw_head == s_idx && lw_tail == s_idx &&
           !(lpos + CW'(1) < cnt_l)) ||
          (state == S_DR_WR && !(j + CW'(2) < cnt_l))) begin
        if (lside) begin
          ask_cnt <= ask_cnt - CW'(1);
        end else begin
          bid_cnt <= bid_cnt - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cur        <= req;
          ptr        <= '0;
          chk_vld    <= 1'b0;
          found      <= 1'b0;
          free_found <= 1'b0;
          di         <= '0;
          dcnt       <= nd;
          res        <= '{status: ST_MISS, order_id_res: '0, price_res: '0,
                          quantity_res: '0, last: 1'b1};
        end
      end
      S_SCAN: begin
        if (ptr < (SW+1)'(MAX_ORDERS)) begin
          ptr <= ptr + (SW+1)'(1);
        end
        chk_vld  <= (ptr < (SW+1)'(MAX_ORDERS));
        chk_addr <= ptr[SW-1:0];
        if (chk_vld && !vbits[chk_addr] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_addr;
        end
        if (scan_hit) begin
          found <= 1'b1;
          s_idx <= chk_addr;
          sd_q  <= sd_rdata;
        end
      end
      S_SCAN_END: begin
        li       <= '0;
        lchk_vld <= 1'b0;
        lfound   <= 1'b0;
        if (add_mode) begin
          lside  <= cur.side;
          lprice <= cur.price;
          lpos   <= cur.side ? ask_cnt : bid_cnt;
          if (found) begin
            res.status <= ST_DUP;
          end else if (!free_found) begin
            res.status <= ST_ORD_FULL;
          end
        end else begin
          lside  <= sd_q.side;
          lprice <= sd_q.price;
          lpos   <= sd_q.side ? ask_cnt : bid_cnt;
          if (found) begin
            res <= '{status: ST_OK, order_id_res: sd_q.order_id, price_res: sd_q.price,
                     quantity_res: 40'(sd_q.quantity), last: 1'b1};
          end
        end
      end
      S_LSCAN: begin
        if (li < cnt_l) begin
          li <= li + CW'(1);
        end
        lchk_vld <= (li < cnt_l);
        lchk     <= li;
        if (lmatch) begin
          lfound <= 1'b1;
          lpos   <= lchk;
          lw     <= lv_rdata;
        end else if (lahead) begin
          lpos <= lchk;
        end
      end
      S_LSCAN_END: begin
        j <= cnt_l;
        if (add_mode) begin
          if (lfound) begin
            res.status <= ST_OK;
          end else if (cnt_l >= CW'(MAX_LEVELS)) begin
            res.status <= ST_LVL_FULL;
          end
        end
      end
      S_SH_WR: begin
        j <= j - CW'(1);
      end
      S_ADD_NEW: begin
        res.status <= ST_OK;
      end
      S_UNL_WR: begin
        j <= lpos;
      end
      S_DR_WR: begin
        j <= j + CW'(1);
      end
      S_BEST_HD: begin
        s_idx <= lr_head;
      end
      S_BEST_SL: begin
        sd_q     <= sd_rdata;
        res      <= '{status: ST_OK, order_id_res: sd_rdata.order_id,
                      price_res: sd_rdata.price, quantity_res: 40'(sd_rdata.quantity),
                      last: 1'b1};
        lside    <= sd_rdata.side;
        lprice   <= sd_rdata.price;
        li       <= '0;
        lchk_vld <= 1'b0;
        lfound   <= 1'b0;
      end
      S_DEP_WT: begin
        res <= '{status: ST_OK, order_id_res: '0, price_res: lr_price,
                 quantity_res: lr_total, last: (di + CW'(1) == dcnt)};
      end
      S_EMIT: begin
        if (res_take && !res.last) begin
          di <= di + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/price_time_order_book.sv
// ----------------------------------------------------------------------------
// price_time_order_book
// Bounded limit order book with price-time priority on integer price ticks.
// ----------------------------------------------------------------------------
// The req channel carries one request: add, cancel, best bid or ask, pop best
// bid or ask, or depth of one side. The rsp channel returns one result per
// request, or one per reported level for depth, the final one marked last.
// Requests are taken one at a time; req_stall stays high until the final
// result of the current request sits in the output register.
// Add scans the slot memory by id, one slot per cycle, then scans the levels
// of its side, and shifts the later levels by one, one at a time, when a new
// level is inserted. Cancel stops its scan at the matching slot and then
// scans and unlinks like a pop.
// Best and pop read the head order of the best level; pop then unlinks it, and
// removing an emptied level moves the later levels up one at a time.
// Depth reports its levels one at a time.
// A result waits in the output register while rsp_stall is high; the engine
// holds the next result until the register frees up, and nothing is lost.
// Reset clears the order valid bits and level counts; the memories need no
// clearing pass.
// ----------------------------------------------------------------------------
module price_time_order_book #(
  parameter int MAX_ORDERS = ptob_pkg::MAX_ORDERS_DEF,
  parameter int MAX_LEVELS = ptob_pkg::MAX_LEVELS_DEF,
  parameter int MAX_DEPTH  = ptob_pkg::MAX_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ptob_pkg::req_t req,
  input  logic           req_valid,
  output logic           req_stall,
  output ptob_pkg::rsp_t rsp,
  output logic           rsp_valid,
  input  logic           rsp_stall
);
  import ptob_pkg::*;

  rsp_t res;
  logic res_valid, res_take;

  ptob_engine #(
    .MAX_ORDERS(MAX_ORDERS),
    .MAX_LEVELS(MAX_LEVELS),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .res      (res),
    .res_valid(res_valid),
    .res_take (res_take)
  );

  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

endmodule
